[design/wccv_pkg.sv]
package wccv_pkg;

  localparam int READ_COUNT   = 64;
  localparam int COUNTER_BITS = 16;
  localparam int READ_IDX_W   = $clog2(READ_COUNT);

  localparam int RD_W      = 6;
  localparam int SYM_W     = 3;
  localparam int WEIGHT_W  = 8;
  localparam int SCORE_W   = 14;
  localparam int SYM_COUNT = 6;
  localparam int OUT_CNT_W = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  localparam logic [SYM_W-1:0] SYM_GAP     = 3'd4;
  localparam logic [SYM_W-1:0] SYM_MISSING = 3'd5;

  localparam logic [SCORE_W-1:0]      SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [COUNTER_BITS-1:0] CNT_MAX   = {COUNTER_BITS{1'b1}};

  localparam logic FUNC_CALL  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic KIND_CONS  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOTE,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT,
    ST_QUERY,
    ST_QRESP
  } state_e;

  typedef struct packed {
    logic call_we;
    logic query_load;
    logic vote_load;
    logic sweep_issue;
    logic column_clear;
    logic out_cons;
    logic out_query;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [COUNTER_BITS-1:0] sub;
    logic [COUNTER_BITS-1:0] ins;
    logic [COUNTER_BITS-1:0] del;
    logic [COUNTER_BITS-1:0] cmp;
  } counters_t;

  function automatic logic [COUNTER_BITS-1:0] bump(input logic [COUNTER_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNTER_BITS'(1);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] clip_out(input logic [COUNTER_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[OUT_CNT_W-1:0];
  endfunction

endpackage

[design/weighted_column_consensus_vote.sv]
// Weighted consensus vote over alignment columns. Each call request adds its
// weight to its symbol's score; the request with tlast high closes the
// column: a vote state, then a walk over all 64 reads (one read a cycle
// through the counter memory), a drain state that finishes the last counter
// write and an emit state that loads the result register. Input stays blocked
// until the consensus result is loaded. A counter query result comes through
// the registered memory read. Both wait longer while an earlier result is
// still held. Input is accepted only between these walks; the output register
// holds one result while the next request is taken. founder_read may be
// written only while the block is idle.
module weighted_column_consensus_vote import wccv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RD_W-1:0]       cfg_wdata_i,      // founder_read
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [5:0] read_index, [8:6] call_symbol, [16:9] vote_weight, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,   // func
  input  logic                  s_axis_tlast_i,   // column_end
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [2:0] consensus_symbol, [18:3] compared_columns, [34:19] deletion_count,
  // [50:35] insertion_count, [66:51] substitution_count, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o    // result_kind
);

  dp_cmd_t    cmd;
  dp_status_t status;

  wccv_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  wccv_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

[design/wccv_ctrl.sv]
module wccv_ctrl import wccv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tuser_i,
  input  logic       s_axis_tlast_i,
  output logic       s_axis_tready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == FUNC_QUERY) begin
            cmd_o.query_load = 1'b1;
            state_d          = ST_QUERY;
          end else begin
            cmd_o.call_we = 1'b1;
            if (s_axis_tlast_i) begin
              state_d = ST_VOTE;
            end
          end
        end
      end
      ST_VOTE: begin
        cmd_o.vote_load = 1'b1;
        state_d         = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.sweep_issue = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.column_clear = 1'b1;
        state_d            = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_cons = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_QUERY: begin
        state_d = ST_QRESP;
      end
      ST_QRESP: begin
        if (status_i.out_free) begin
          cmd_o.out_query = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/wccv_datapath.sv]
module wccv_datapath import wccv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RD_W-1:0]       cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  m_axis_tready_i,
  output logic                  m_axis_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o
);

  logic [RD_W-1:0]     in_rd;
  logic [SYM_W-1:0]    in_sym_raw, in_sym;
  logic [WEIGHT_W-1:0] in_w;
  logic                in_rd_ok;
  logic [READ_IDX_W-1:0] in_idx;

  assign in_rd      = s_axis_tdata_i[RD_W-1:0];
  assign in_sym_raw = s_axis_tdata_i[RD_W+SYM_W-1:RD_W];
  assign in_w       = s_axis_tdata_i[RD_W+SYM_W+WEIGHT_W-1:RD_W+SYM_W];
  assign in_sym     = (in_sym_raw > SYM_MISSING) ? SYM_MISSING : in_sym_raw;
  assign in_rd_ok   = (32'(in_rd) < READ_COUNT);
  assign in_idx     = READ_IDX_W'(in_rd);

  logic [RD_W-1:0]    founder_read_q;
  logic [SCORE_W-1:0] scores_q [SYM_COUNT];
  logic [SYM_W-1:0]   founder_sym_q;
  logic [READ_COUNT-1:0] seen_q;
  logic [READ_COUNT-1:0] cnt_valid_q;

  logic [SYM_W-1:0] calls_mem [READ_COUNT];
  counters_t        cnt_mem   [READ_COUNT];

  logic [READ_IDX_W-1:0] idx_q;
  logic [READ_IDX_W-1:0] q_addr_q;
  logic                  q_ok_q;
  logic [SYM_W-1:0]      cons_q;

  logic [READ_IDX_W-1:0] rd_addr;
  counters_t             rd_cnt_q;
  logic                  rd_cnt_valid_q;
  logic [SYM_W-1:0]      rd_call_q;
  logic                  p_seen_q;
  logic                  p_valid_q;
  logic [READ_IDX_W-1:0] p_idx_q;

  logic                  out_valid_q;
  logic                  out_kind_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // score accumulation
  logic [SCORE_W:0]   score_sum;
  logic [SCORE_W-1:0] score_new;

  assign score_sum = {1'b0, scores_q[in_sym]} + (SCORE_W+1)'(in_w);
  assign score_new = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];

  // vote
  logic [SCORE_W-1:0] best;
  logic [SYM_W-1:0]   win, cons_d;
  logic               f_match;

  always_comb begin
    best    = '0;
    win     = '0;
    f_match = 1'b0;
    for (int s = 0; s < int'(SYM_GAP) + 1; s++) begin
      if (scores_q[s] > best) begin
        best = scores_q[s];
        win  = SYM_W'(s);
      end
    end
    for (int s = 0; s < int'(SYM_GAP) + 1; s++) begin
      if (founder_sym_q == SYM_W'(s) && scores_q[s] == best) begin
        f_match = 1'b1;
      end
    end
    if (best == '0) begin
      cons_d = (scores_q[SYM_MISSING] != '0) ? SYM_MISSING : founder_sym_q;
    end else if (f_match) begin
      cons_d = founder_sym_q;
    end else begin
      cons_d = win;
    end
  end

  // counter update for the read in the second sweep stage
  counters_t cur, upd;
  logic      cnt_we;

  always_comb begin
    cur    = rd_cnt_valid_q ? rd_cnt_q : '0;
    upd    = cur;
    cnt_we = p_valid_q && p_seen_q && (rd_call_q != SYM_MISSING) && (cons_q != SYM_MISSING);
    upd.cmp = bump(cur.cmp);
    if (rd_call_q < SYM_GAP && cons_q < SYM_GAP && rd_call_q != cons_q) begin
      upd.sub = bump(cur.sub);
    end else if (rd_call_q < SYM_GAP && cons_q == SYM_GAP) begin
      upd.ins = bump(cur.ins);
    end else if (cons_q < SYM_GAP && rd_call_q == SYM_GAP) begin
      upd.del = bump(cur.del);
    end
  end

  assign rd_addr = cmd_i.sweep_issue ? idx_q : q_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      founder_read_q <= '0;
      founder_sym_q  <= SYM_MISSING;
      seen_q         <= '0;
      cnt_valid_q    <= '0;
      idx_q          <= '0;
      p_valid_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      for (int s = 0; s < SYM_COUNT; s++) begin
        scores_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        founder_read_q <= cfg_wdata_i;
      end
      if (cmd_i.call_we && in_rd_ok) begin
        scores_q[in_sym] <= score_new;
        seen_q[in_idx]   <= 1'b1;
        if (in_rd == founder_read_q) begin
          founder_sym_q <= in_sym;
        end
      end
      if (cmd_i.column_clear) begin
        seen_q        <= '0;
        founder_sym_q <= SYM_MISSING;
        for (int s = 0; s < SYM_COUNT; s++) begin
          scores_q[s] <= '0;
        end
      end
      if (cmd_i.vote_load) begin
        idx_q <= '0;
      end else if (cmd_i.sweep_issue) begin
        idx_q <= status_o.sweep_last ? '0 : idx_q + READ_IDX_W'(1);
      end
      p_valid_q <= cmd_i.sweep_issue;
      if (cnt_we) begin
        cnt_valid_q[p_idx_q] <= 1'b1;
      end
      if (cmd_i.out_cons || cmd_i.out_query) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.call_we && in_rd_ok) begin
      calls_mem[in_idx] <= in_sym;
    end
    if (cnt_we) begin
      cnt_mem[p_idx_q] <= upd;
    end
    rd_cnt_q       <= cnt_mem[rd_addr];
    rd_call_q      <= calls_mem[rd_addr];
    rd_cnt_valid_q <= cnt_valid_q[rd_addr];
    p_seen_q       <= seen_q[rd_addr];
    p_idx_q        <= rd_addr;
    if (cmd_i.query_load) begin
      q_addr_q <= in_idx;
      q_ok_q   <= in_rd_ok;
    end
    if (cmd_i.vote_load) begin
      cons_q <= cons_d;
    end
    if (cmd_i.out_cons) begin
      out_kind_q <= KIND_CONS;
      out_data_q <= {(OUT_DATA_W-SYM_W)'(0), cons_q};
    end else if (cmd_i.out_query) begin
      out_kind_q <= KIND_QUERY;
      out_data_q <= {(OUT_DATA_W-SYM_W-4*OUT_CNT_W)'(0),
                     clip_out(q_ok_q ? cur.sub : '0),
                     clip_out(q_ok_q ? cur.ins : '0),
                     clip_out(q_ok_q ? cur.del : '0),
                     clip_out(q_ok_q ? cur.cmp : '0),
                     SYM_W'(0)};
    end
  end

  assign status_o.sweep_last = (idx_q == READ_IDX_W'(READ_COUNT - 1));
  assign status_o.out_free   = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

[tb/weighted_column_consensus_vote_test.sv]
module weighted_column_consensus_vote_test;
  import wccv_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 3000;

  localparam logic [SYM_W-1:0] BASE_A   = 3'd0;
  localparam logic [SYM_W-1:0] BASE_C   = 3'd1;
  localparam logic [SYM_W-1:0] BASE_G   = 3'd2;
  localparam logic [SYM_W-1:0] BASE_T   = 3'd3;
  localparam logic [SYM_W-1:0] SYM_BAD6 = 3'd6;
  localparam logic [SYM_W-1:0] SYM_BAD7 = 3'd7;

  typedef struct packed {
    logic                func;
    logic [RD_W-1:0]     rd;
    logic [SYM_W-1:0]    sym;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } vote_req_t;

  typedef struct packed {
    logic                 kind;
    logic [SYM_W-1:0]     sym;
    logic [OUT_CNT_W-1:0] cmp;
    logic [OUT_CNT_W-1:0] del;
    logic [OUT_CNT_W-1:0] ins;
    logic [OUT_CNT_W-1:0] sub;
  } vote_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [RD_W-1:0]       cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  weighted_column_consensus_vote u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted block state
  logic [RD_W-1:0]         founder_cfg = '0;
  logic [SYM_W-1:0]        founder_sym = SYM_MISSING;
  logic [SYM_W-1:0]        call_sym[READ_COUNT];
  bit                      call_seen[READ_COUNT];
  int unsigned             sym_score[SYM_COUNT];
  logic [COUNTER_BITS-1:0] cmp_cnt[READ_COUNT];
  logic [COUNTER_BITS-1:0] del_cnt[READ_COUNT];
  logic [COUNTER_BITS-1:0] ins_cnt[READ_COUNT];
  logic [COUNTER_BITS-1:0] sub_cnt[READ_COUNT];

  vote_req_t    request_q[$];
  vote_result_t result_q[$];
  vote_req_t    on_bus;
  bit           bus_busy = 1'b0;
  int           send_idle_pct = 12;
  int           recv_idle_pct = 52;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  initial begin
    for (int r = 0; r < READ_COUNT; r++) begin
      call_sym[r]  = '0;
      call_seen[r] = 1'b0;
      cmp_cnt[r]   = '0;
      del_cnt[r]   = '0;
      ins_cnt[r]   = '0;
      sub_cnt[r]   = '0;
    end
    for (int s = 0; s < SYM_COUNT; s++) sym_score[s] = 0;
  end

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    return (v == {COUNTER_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic void tally_request(input vote_req_t q);
    vote_result_t     res;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] win;
    logic [SYM_W-1:0] c;
    int unsigned      best;
    int unsigned      sum;
    res = '0;
    if (q.func == FUNC_QUERY) begin
      res.kind = KIND_QUERY;
      res.cmp  = OUT_CNT_W'(cmp_cnt[q.rd]);
      res.del  = OUT_CNT_W'(del_cnt[q.rd]);
      res.ins  = OUT_CNT_W'(ins_cnt[q.rd]);
      res.sub  = OUT_CNT_W'(sub_cnt[q.rd]);
      result_q.insert(result_q.size(), res);
      return;
    end
    sym = (q.sym > SYM_MISSING) ? SYM_MISSING : q.sym;
    sum = sym_score[sym] + q.weight;
    sym_score[sym] = (sum > SCORE_MAX) ? SCORE_MAX : sum;
    call_sym[q.rd]  = sym;
    call_seen[q.rd] = 1'b1;
    if (q.rd == founder_cfg) founder_sym = sym;
    if (!q.last) return;

    best = 0;
    win  = '0;
    for (int s = 0; s <= SYM_GAP; s++) begin
      if (sym_score[s] > best) begin
        best = sym_score[s];
        win  = SYM_W'(s);
      end
    end
    if (best == 0) begin
      win = (sym_score[SYM_MISSING] > 0) ? SYM_MISSING : founder_sym;
    end else if (founder_sym <= SYM_GAP && sym_score[founder_sym] == best) begin
      win = founder_sym;
    end

    for (int r = 0; r < READ_COUNT; r++) begin
      c = call_sym[r];
      if (call_seen[r] && c != SYM_MISSING && win != SYM_MISSING) begin
        cmp_cnt[r] = sat_inc(cmp_cnt[r]);
        if (c < SYM_GAP && win < SYM_GAP && c != win) sub_cnt[r] = sat_inc(sub_cnt[r]);
        else if (c < SYM_GAP && win == SYM_GAP) ins_cnt[r] = sat_inc(ins_cnt[r]);
        else if (win < SYM_GAP && c == SYM_GAP) del_cnt[r] = sat_inc(del_cnt[r]);
      end
      call_seen[r] = 1'b0;
    end
    for (int s = 0; s < SYM_COUNT; s++) sym_score[s] = 0;
    founder_sym = SYM_MISSING;

    res.kind = KIND_CONS;
    res.sym  = win;
    result_q.insert(result_q.size(), res);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        tally_request(on_bus);
        bus_busy = 1'b0;
      end
      if (!s_tvalid || s_tready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = request_q.pop_front();
          bus_busy = 1'b1;
          s_tvalid <= 1'b1;
          s_tdata  <= IN_DATA_W'({on_bus.weight, on_bus.sym, on_bus.rd});
          s_tuser  <= on_bus.func;
          s_tlast  <= on_bus.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vote_result_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, kind %0d", m_tuser));
        end else begin
          want = result_q.pop_front();
          if (m_tuser !== want.kind)
            report_mismatch($sformatf("result_kind got %0d want %0d", m_tuser, want.kind));
          if (m_tdata[2:0] !== want.sym)
            report_mismatch($sformatf("consensus_symbol got %0d want %0d",
                                      m_tdata[2:0], want.sym));
          if (m_tdata[18:3] !== want.cmp)
            report_mismatch($sformatf("compared_columns got %0d want %0d",
                                      m_tdata[18:3], want.cmp));
          if (m_tdata[34:19] !== want.del)
            report_mismatch($sformatf("deletion_count got %0d want %0d",
                                      m_tdata[34:19], want.del));
          if (m_tdata[50:35] !== want.ins)
            report_mismatch($sformatf("insertion_count got %0d want %0d",
                                      m_tdata[50:35], want.ins));
          if (m_tdata[66:51] !== want.sub)
            report_mismatch($sformatf("substitution_count got %0d want %0d",
                                      m_tdata[66:51], want.sub));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("weighted_column_consensus_vote_test: FAIL");
    $finish;
  end

  task automatic push_request(input logic func, input logic [RD_W-1:0] rd,
                              input logic [SYM_W-1:0] sym, input logic [WEIGHT_W-1:0] w,
                              input logic last);
    request_q.insert(request_q.size(), vote_req_t'{func, rd, sym, w, last});
  endtask

  task automatic write_founder(input logic [RD_W-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    founder_cfg = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || bus_busy || result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(input int n);
    int               left;
    int               len;
    int               roll;
    logic [RD_W-1:0]  rd;
    logic [SYM_W-1:0] sym;
    logic [WEIGHT_W-1:0] w;
    left = n;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 12) begin
          push_request(FUNC_QUERY, RD_W'($urandom_range(63)), SYM_W'($urandom_range(7)),
                       WEIGHT_W'($urandom_range(255)), 1'($urandom_range(1)));
          left--;
        end
        rd = ($urandom_range(3) == 0) ? founder_cfg : RD_W'($urandom_range(63));
        roll = $urandom_range(99);
        if (roll < 64) sym = SYM_W'($urandom_range(3));
        else if (roll < 82) sym = SYM_GAP;
        else if (roll < 94) sym = SYM_MISSING;
        else sym = SYM_W'($urandom_range(6, 7));
        // coarse weights make ties common
        w = ($urandom_range(2) == 0) ? WEIGHT_W'(64 * $urandom_range(4))
                                     : WEIGHT_W'($urandom_range(255));
        push_request(FUNC_CALL, rd, sym, w, i == len - 1);
        left--;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_founder(6'd3);
    push_request(FUNC_QUERY, 6'd0, SYM_BAD7, 8'd255, 1'b1);
    // nothing scores, founder silent
    push_request(FUNC_CALL, 6'd10, SYM_MISSING, 8'd0, 1'b1);
    // nothing scores, founder called
    push_request(FUNC_CALL, 6'd3, BASE_G, 8'd0, 1'b0);
    push_request(FUNC_CALL, 6'd4, BASE_C, 8'd0, 1'b1);
    // tie broken by founder
    push_request(FUNC_CALL, 6'd3, SYM_GAP, 8'd100, 1'b0);
    push_request(FUNC_CALL, 6'd7, BASE_A, 8'd100, 1'b0);
    push_request(FUNC_CALL, 6'd8, SYM_MISSING, 8'd255, 1'b1);
    // tie to lower code
    push_request(FUNC_CALL, 6'd9, BASE_T, 8'd50, 1'b0);
    push_request(FUNC_CALL, 6'd10, BASE_C, 8'd50, 1'b1);
    // only missing scored
    push_request(FUNC_CALL, 6'd11, SYM_MISSING, 8'd1, 1'b1);
    push_request(FUNC_CALL, 6'd12, SYM_BAD7, 8'd200, 1'b0);
    push_request(FUNC_CALL, 6'd13, SYM_BAD6, 8'd10, 1'b1);
    // repeated read: weights add, last symbol kept
    push_request(FUNC_CALL, 6'd20, BASE_A, 8'd10, 1'b0);
    push_request(FUNC_CALL, 6'd20, BASE_G, 8'd10, 1'b0);
    push_request(FUNC_CALL, 6'd63, BASE_G, 8'd5, 1'b1);
    push_request(FUNC_CALL, 6'd3, BASE_A, 8'd255, 1'b0);
    push_request(FUNC_CALL, 6'd63, SYM_GAP, 8'd255, 1'b1);
    push_request(FUNC_QUERY, 6'd3, BASE_A, 8'd0, 1'b0);
    push_request(FUNC_QUERY, 6'd4, SYM_GAP, 8'd17, 1'b1);
    push_request(FUNC_QUERY, 6'd7, SYM_MISSING, 8'd128, 1'b0);
    push_request(FUNC_QUERY, 6'd9, BASE_T, 8'd1, 1'b1);
    push_request(FUNC_QUERY, 6'd63, SYM_BAD6, 8'd254, 1'b0);
    wait_drained();

    write_founder(6'd63);
    queue_random(300);
    wait_drained();

    send_idle_pct = 52;
    recv_idle_pct = 12;
    write_founder(6'd0);
    queue_random(300);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_founder(RD_W'($urandom_range(1, 62)));
    // both scores saturate: a tie that unsaturated sums would not give
    for (int i = 0; i < 65; i++) push_request(FUNC_CALL, RD_W'(i), BASE_A, 8'd255, 1'b0);
    for (int i = 0; i < 66; i++)
      push_request(FUNC_CALL, RD_W'(i + 1), BASE_C, 8'd255, i == 65);
    queue_random(170);
    wait_drained();

    if (mismatches == 0) begin
      $display("weighted_column_consensus_vote_test: PASS");
    end else begin
      $display("weighted_column_consensus_vote_test: FAIL");
    end
    $finish;
  end

endmodule

[weighted_column_consensus_vote.f]
design/wccv_pkg.sv
design/wccv_ctrl.sv
design/wccv_datapath.sv
design/weighted_column_consensus_vote.sv
tb/weighted_column_consensus_vote_test.sv
